/* rtl/gamepad_merge_hold_turbo_core_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the joypad merge core
// Shared property forms for the checker.
// ----------------------------------------------------------------------------
`ifndef GAMEPAD_MERGE_HOLD_TURBO_CORE_DEFINES_SVH
`define GAMEPAD_MERGE_HOLD_TURBO_CORE_DEFINES_SVH

// The consequent holds in the same cycle as the antecedent.
`define GMHT_ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gmht assertion failed");

// The consequent holds in the cycle after the antecedent.
`define GMHT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gmht assertion failed");

`endif

/* rtl/gmht_pkg.sv */
// ----------------------------------------------------------------------------
// Joypad merge package
// Widths, bit positions and helpers shared by the joypad merge modules.
// ----------------------------------------------------------------------------
package gmht_pkg;

  localparam int COUNT_BITS = 8;
  localparam int WORD_W     = 12;
  localparam int JOY_W      = 11;
  localparam int HOLD_W     = 8;
  localparam int NUM_HELD   = 8;
  localparam int NUM_SRC    = 4;
  localparam int CMP_W      = (COUNT_BITS > HOLD_W) ? COUNT_BITS : HOLD_W;

  localparam logic [COUNT_BITS-1:0] CNT_MAX    = '1;
  localparam logic [HOLD_W-1:0]     HOLD_RESET = HOLD_W'(3);

  localparam int BIT_TURBO  = 10;
  localparam int BIT_TOGGLE = 11;

  localparam logic [WORD_W-1:0] PASS_MASK = WORD_W'(12);
  localparam logic [WORD_W-1:0] LR_MASK   = WORD_W'(48);
  localparam logic [WORD_W-1:0] UD_MASK   = WORD_W'(192);
  localparam logic [WORD_W-1:0] RIGHT_BIT = WORD_W'(16);
  localparam logic [WORD_W-1:0] DOWN_BIT  = WORD_W'(128);

  typedef struct packed {
    logic fire;
    logic live;
  } step_t;

  function automatic logic [NUM_HELD-1:0] held_gather(input logic [WORD_W-1:0] w);
    held_gather = {w[9], w[8], w[7], w[6], w[5], w[4], w[1], w[0]};
  endfunction

  function automatic logic [WORD_W-1:0] held_scatter(input logic [NUM_HELD-1:0] h);
    held_scatter = {2'b00, h[7], h[6], h[5], h[4], h[3], h[2], 2'b00, h[1], h[0]};
  endfunction

endpackage

/* rtl/gmht_stretch.sv */
// ----------------------------------------------------------------------------
// Button stretch
// Per-button saturating release counters that keep a released button
// reported for a programmable number of polls.
// ----------------------------------------------------------------------------
module gmht_stretch (
  input  logic                           clk,
  input  logic                           rst,
  input  gmht_pkg::step_t                step,
  input  logic [gmht_pkg::NUM_HELD-1:0]  pressed,
  input  logic [gmht_pkg::HOLD_W-1:0]    hold_frames,
  output logic [gmht_pkg::NUM_HELD-1:0]  held
);
  import gmht_pkg::*;

  logic [COUNT_BITS-1:0] release_count      [NUM_HELD];
  logic [COUNT_BITS-1:0] release_count_next [NUM_HELD];

  always_comb begin
    for (int i = 0; i < NUM_HELD; i++) begin
      held[i] = pressed[i] |
                ((CMP_W'(release_count[i]) < CMP_W'(hold_frames)) &&
                 (release_count[i] != CNT_MAX));
      if (pressed[i]) begin
        release_count_next[i] = '0;
      end else if (release_count[i] == CNT_MAX) begin
        release_count_next[i] = release_count[i];
      end else begin
        release_count_next[i] = release_count[i] + COUNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_HELD; i++) begin
        release_count[i] <= CNT_MAX;
      end
    end else if (step.fire && step.live) begin
      release_count <= release_count_next;
    end
  end

endmodule

/* rtl/gmht_turbo.sv */
// ----------------------------------------------------------------------------
// Turbo latch
// Flips the turbo latch on a release of the toggle button on any source
// and applies the momentary turbo button.
// ----------------------------------------------------------------------------
module gmht_turbo (
  input  logic                          clk,
  input  logic                          rst,
  input  gmht_pkg::step_t               step,
  input  logic [gmht_pkg::NUM_SRC-1:0]  toggle,
  input  logic                          turbo_any,
  output logic                          latch_now,
  output logic                          use_turbo
);
  import gmht_pkg::*;

  logic               turbo_latch;
  logic [NUM_SRC-1:0] last_toggle;

  // Any release edge flips the latch once; the source order cannot change that.
  assign latch_now = turbo_latch ^ (|(last_toggle & ~toggle));
  assign use_turbo = latch_now ^ turbo_any;

  always_ff @(posedge clk) begin
    if (rst) begin
      turbo_latch <= 1'b0;
      last_toggle <= '0;
    end else if (step.fire && step.live) begin
      turbo_latch <= latch_now;
      last_toggle <= toggle;
    end
  end

endmodule

/* rtl/gamepad_merge_hold_turbo_core.sv */
// ----------------------------------------------------------------------------
// Joypad merge core
// Merges four source button words into one joypad word per poll.
// ----------------------------------------------------------------------------
// One poll is accepted every clock cycle while in_ready is high: polls are
// captured in an input register, merged, stretched and turbo-adjusted in one
// pass, and held in an output register until taken. The input register
// advances whenever the result register is free or is being emptied, so polls
// flow back to back while results are taken; a waiting result stops new polls
// once the input register also holds one.
// The hold_frames register may be written at any time the core is idle.
module gamepad_merge_hold_turbo_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic [gmht_pkg::HOLD_W-1:0]  cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         sources_ready,
  input  logic [gmht_pkg::WORD_W-1:0]  keyboard_word,
  input  logic [gmht_pkg::WORD_W-1:0]  gamepad_word,
  input  logic [gmht_pkg::WORD_W-1:0]  touch_word,
  input  logic [gmht_pkg::WORD_W-1:0]  hid_word,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [gmht_pkg::JOY_W-1:0]   joypad_bits,
  output logic                         turbo_latched
);
  import gmht_pkg::*;

  logic [HOLD_W-1:0]   hold_reg;
  logic                s1_valid;
  logic                s1_live;
  logic [WORD_W-1:0]   s1_kbd;
  logic [WORD_W-1:0]   s1_pad;
  logic [WORD_W-1:0]   s1_touch;
  logic [WORD_W-1:0]   s1_hid;
  logic                s1_adv;
  step_t               step;
  logic [WORD_W-1:0]   any;
  logic [NUM_HELD-1:0] held;
  logic [WORD_W-1:0]   merged;
  logic [WORD_W-1:0]   fixed;
  logic [JOY_W-1:0]    joy_next;
  logic                latch_now;
  logic                use_turbo;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_reg <= HOLD_RESET;
    end else if (cfg_write) begin
      hold_reg <= cfg_wdata;
    end
  end

  assign s1_adv   = !out_valid || out_ready;
  assign in_ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_live  <= sources_ready;
      s1_kbd   <= keyboard_word;
      s1_pad   <= gamepad_word;
      s1_touch <= touch_word;
      s1_hid   <= hid_word;
    end
  end

  assign step.fire = s1_valid && s1_adv;
  assign step.live = s1_live;

  assign any = s1_kbd | s1_pad | s1_touch | s1_hid;

  gmht_stretch u_stretch (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .pressed     (held_gather(any)),
    .hold_frames (hold_reg),
    .held        (held)
  );

  gmht_turbo u_turbo (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .toggle    ({s1_hid[BIT_TOGGLE], s1_touch[BIT_TOGGLE],
                 s1_pad[BIT_TOGGLE], s1_kbd[BIT_TOGGLE]}),
    .turbo_any (any[BIT_TURBO]),
    .latch_now (latch_now),
    .use_turbo (use_turbo)
  );

  always_comb begin
    merged = held_scatter(held) | (any & PASS_MASK);
    fixed  = merged;
    if ((merged & LR_MASK) == LR_MASK) begin
      fixed = fixed & ~RIGHT_BIT;
    end
    if ((merged & UD_MASK) == UD_MASK) begin
      fixed = fixed & ~DOWN_BIT;
    end
    fixed[BIT_TURBO] = use_turbo;
    joy_next = JOY_W'(fixed);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step.fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step.fire) begin
      joypad_bits   <= s1_live ? joy_next : '0;
      turbo_latched <= s1_live && latch_now;
    end
  end

endmodule

/* rtl/gmht_checker.sv */
// ----------------------------------------------------------------------------
// Joypad merge checker
// Port-level properties of the joypad merge core, bound to the top level.
// ----------------------------------------------------------------------------
`include "gamepad_merge_hold_turbo_core_defines.svh"

module gmht_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [gmht_pkg::JOY_W-1:0]   joypad_bits
);
  import gmht_pkg::*;

  `GMHT_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(joypad_bits))
  `GMHT_ASSERT_SAME(a_no_left_right, clk, rst, out_valid, !(joypad_bits[4] && joypad_bits[5]))
  `GMHT_ASSERT_SAME(a_no_up_down, clk, rst, out_valid, !(joypad_bits[6] && joypad_bits[7]))

endmodule

bind gamepad_merge_hold_turbo_core gmht_checker u_gmht_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .joypad_bits (joypad_bits)
);
